// ===== rtl/trsts_pkg.sv =====
// ----------------------------------------------------------------------------
// trsts_pkg
// Shared types and constants for the two-row scrolling text sequencer.
// ----------------------------------------------------------------------------
package trsts_pkg;

  // widths fixed by the word format, and the default column count
  localparam int CHAR_W      = 8;
  localparam int COL_W       = 5;
  localparam int COLUMNS_DEF = 16;

  // display addresses and character codes
  localparam logic [CHAR_W-1:0] ADDR_TOP    = 8'h00;
  localparam logic [CHAR_W-1:0] ADDR_BOTTOM = 8'h40;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_RETURN   = 8'h0d;

  // output operation codes
  localparam logic OP_ADDR = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR_TOP,
    ST_ROW_TOP,
    ST_ADDR_BOT,
    ST_ROW_BOT
  } trsts_state_t;

  // storage control from sequencer to row store
  typedef struct packed {
    logic              line_we;
    logic              shadow_we;
    logic [COL_W-1:0]  idx;
    logic [CHAR_W-1:0] wdata;
  } trsts_ctl_t;

endpackage

// ===== rtl/two_row_scrolling_text_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// two_row_scrolling_text_sequencer_unit
// Turns a character stream into display commands for a scrolling two-row view.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_stall/in_char_code) takes one character word.
//   other codes are stored at the current column, with no output.
//   carriage return is dropped. newline, or filling the last column, starts
//   a scroll: the block emits on the out_ channel a top-row address word,
//   COLUMNS data words of the old bottom row, a bottom-row address word and
//   COLUMNS data words of the new line, the final word flagged by out_last.
//   first result word appears the cycle after the triggering word is taken.
//   a scroll holds in_stall until its final word is taken: one shared
//   increment/compare unit steps the row index, one word per cycle while
//   out_stall is low.
//   out_stall freezes the sequencer; the offered word is held unchanged.
//   reset returns to idle, column zero, and the bottom shadow to spaces.
// ----------------------------------------------------------------------------
module two_row_scrolling_text_sequencer_unit #(
  parameter int COLUMNS = trsts_pkg::COLUMNS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [trsts_pkg::CHAR_W-1:0] in_char_code,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_op,
  output logic [trsts_pkg::CHAR_W-1:0] out_value,
  output logic                         out_last
);
  import trsts_pkg::*;

  trsts_ctl_t        ctl;
  logic [CHAR_W-1:0] line_q;
  logic [CHAR_W-1:0] shadow_q;

  // sequencer
  trsts_seq #(
    .COLUMNS(COLUMNS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_op       (out_op),
    .out_value    (out_value),
    .out_last     (out_last),
    .ctl          (ctl),
    .line_q       (line_q),
    .shadow_q     (shadow_q)
  );

  // row storage
  trsts_store #(
    .COLUMNS(COLUMNS)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .line_q   (line_q),
    .shadow_q (shadow_q)
  );

endmodule

// ===== rtl/trsts_store.sv =====
// ----------------------------------------------------------------------------
// trsts_store
// Line buffer and bottom row shadow, one shared index for write and read.
// ----------------------------------------------------------------------------
module trsts_store #(
  parameter int COLUMNS = trsts_pkg::COLUMNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  trsts_pkg::trsts_ctl_t      ctl,
  output logic [trsts_pkg::CHAR_W-1:0] line_q,
  output logic [trsts_pkg::CHAR_W-1:0] shadow_q
);
  import trsts_pkg::*;

  localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [CHAR_W-1:0] line_r   [COLUMNS];
  logic [CHAR_W-1:0] shadow_r [COLUMNS];
  logic [IDX_W-1:0]  idx;

  assign idx = ctl.idx[IDX_W-1:0];

  // line buffer, contents undefined until written
  always_ff @(posedge clk) begin
    if (ctl.line_we) begin
      line_r[idx] <= ctl.wdata;
    end
  end

  // bottom shadow, display assumed cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COLUMNS; i++) begin
        shadow_r[i] <= CH_SPACE;
      end
    end else if (ctl.shadow_we) begin
      shadow_r[idx] <= ctl.wdata;
    end
  end

  assign line_q   = line_r[idx];
  assign shadow_q = shadow_r[idx];

endmodule

// ===== rtl/trsts_seq.sv =====
// ----------------------------------------------------------------------------
// trsts_seq
// Sequencer with one shared increment and compare unit for column and index.
// ----------------------------------------------------------------------------
module trsts_seq #(
  parameter int COLUMNS = trsts_pkg::COLUMNS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [trsts_pkg::CHAR_W-1:0] in_char_code,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_op,
  output logic [trsts_pkg::CHAR_W-1:0] out_value,
  output logic                         out_last,
  output trsts_pkg::trsts_ctl_t        ctl,
  input  logic [trsts_pkg::CHAR_W-1:0] line_q,
  input  logic [trsts_pkg::CHAR_W-1:0] shadow_q
);
  import trsts_pkg::*;

  trsts_state_t      state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [COL_W-1:0]  idx_r, idx_nxt;
  logic [COL_W-1:0]  opnd, sum;
  logic              hit;
  logic [CHAR_W-1:0] pad_char;

  // shared increment and end-of-row compare
  assign opnd = (state_r == ST_IDLE) ? col_r : idx_r;
  assign sum  = opnd + COL_W'(1);
  assign hit  = (sum == COL_W'(COLUMNS));

  // columns past the last written one read as spaces
  assign pad_char = (idx_r < col_r) ? line_q : CH_SPACE;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // next state and outputs
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    idx_nxt       = idx_r;
    in_stall      = (state_r != ST_IDLE);
    out_valid     = (state_r != ST_IDLE);
    out_op        = OP_DATA;
    out_value     = shadow_q;
    out_last      = 1'b0;
    ctl.line_we   = 1'b0;
    ctl.shadow_we = 1'b0;
    ctl.idx       = idx_r;
    ctl.wdata     = pad_char;
    unique case (state_r)
      ST_IDLE: begin
        ctl.idx   = col_r;
        ctl.wdata = in_char_code;
        if (in_valid) begin
          if (in_char_code == CH_NEWLINE) begin
            state_nxt = ST_ADDR_TOP;
          end else if (in_char_code != CH_RETURN) begin
            ctl.line_we = 1'b1;
            col_nxt     = sum;
            if (hit) begin
              state_nxt = ST_ADDR_TOP;
            end
          end
        end
      end
      ST_ADDR_TOP: begin
        out_op    = OP_ADDR;
        out_value = ADDR_TOP;
        if (!out_stall) begin
          state_nxt = ST_ROW_TOP;
          idx_nxt   = '0;
        end
      end
      ST_ROW_TOP: begin
        out_value = shadow_q;
        if (!out_stall) begin
          if (hit) begin
            state_nxt = ST_ADDR_BOT;
            idx_nxt   = '0;
          end else begin
            idx_nxt = sum;
          end
        end
      end
      ST_ADDR_BOT: begin
        out_op    = OP_ADDR;
        out_value = ADDR_BOTTOM;
        if (!out_stall) begin
          state_nxt = ST_ROW_BOT;
          idx_nxt   = '0;
        end
      end
      ST_ROW_BOT: begin
        out_value = pad_char;
        out_last  = hit;
        if (!out_stall) begin
          // new bottom row becomes the shadow as it goes out
          ctl.shadow_we = 1'b1;
          if (hit) begin
            state_nxt = ST_IDLE;
            col_nxt   = '0;
            idx_nxt   = '0;
          end else begin
            idx_nxt = sum;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/trsts_checker.sv =====
// ----------------------------------------------------------------------------
// trsts_checker
// Port-level checks for the scrolling text sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module trsts_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_op,
  input logic [trsts_pkg::CHAR_W-1:0] out_value,
  input logic                         out_last
);
  import trsts_pkg::*;

  // no new word taken while a scroll is in flight
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during scroll");

  // scroll ends after its last word is taken
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall) |=> !out_valid)
    else $error("output continues past last word");

  // last word is always a data write
  a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_op == OP_DATA))
    else $error("last word is not a data write");

  // address words only point at a row start
  a_addr_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_op == OP_ADDR) |->
      (out_value == ADDR_TOP || out_value == ADDR_BOTTOM))
    else $error("bad display address");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_op) && $stable(out_value) && $stable(out_last)))
    else $error("stalled word changed");

endmodule

bind two_row_scrolling_text_sequencer_unit trsts_checker u_trsts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_op       (out_op),
  .out_value    (out_value),
  .out_last     (out_last)
);

// ===== test/two_row_scrolling_text_sequencer_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_row_scrolling_text_sequencer_unit_test
// Feeds character words into the scrolling sequencer and predicts every
// display word it must produce: the top-row address, the old bottom row from
// a shadow copy, the bottom-row address and the padded new line. Results are
// checked field by field in order. Sender bursts and receiver stalls vary
// over the run, apart from one stretch with neither.
// ----------------------------------------------------------------------------
module two_row_scrolling_text_sequencer_unit_test;
  import trsts_pkg::*;

  localparam int COLS       = COLUMNS_DEF;
  localparam int RAND_CHARS = 430;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 2 * COLS + 8;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] value;
    logic              last;
  } disp_word_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURST,
    STALL_ALTERNATE
  } stall_mode_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic              out_op;
  logic [CHAR_W-1:0] out_value;
  logic              out_last;

  // predicted display state
  logic [CHAR_W-1:0] line_chars [COLS];
  logic [CHAR_W-1:0] bottom_row [COLS];
  logic [COL_W-1:0]  text_col;
  disp_word_t        pending_words [$];

  // run bookkeeping
  int          fails       = 0;
  int          chars_sent  = 0;
  int          scrolls     = 0;
  int          words_seen  = 0;
  int          burst_left  = 0;
  bit          idle_on     = 1'b1;
  bit          stall_on    = 1'b1;
  int          quiet_count = 0;
  logic [7:0]  stall_phase = '0;
  stall_mode_t stall_mode  = STALL_NONE;

  two_row_scrolling_text_sequencer_unit #(
    .COLUMNS(COLS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_op       (out_op),
    .out_value    (out_value),
    .out_last     (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pad the line, queue the scroll words, and move the line into the shadow
  function automatic void queue_scroll();
    for (int i = 0; i < COLS; i++) begin
      if (i >= text_col) line_chars[i] = CH_SPACE;
    end
    text_col = '0;
    pending_words.push_back('{op: OP_ADDR, value: ADDR_TOP, last: 1'b0});
    for (int i = 0; i < COLS; i++) begin
      pending_words.push_back('{op: OP_DATA, value: bottom_row[i], last: 1'b0});
    end
    pending_words.push_back('{op: OP_ADDR, value: ADDR_BOTTOM, last: 1'b0});
    for (int i = 0; i < COLS; i++) begin
      pending_words.push_back('{op: OP_DATA, value: line_chars[i],
                                last: (i == COLS - 1)});
    end
    bottom_row = line_chars;
    scrolls++;
  endfunction

  // state update for one accepted character word
  function automatic void predict_char(input logic [CHAR_W-1:0] c);
    if (c == CH_NEWLINE) begin
      queue_scroll();
    end else if (c != CH_RETURN) begin
      if (text_col >= COLS) text_col = '0;
      line_chars[text_col] = c;
      text_col = text_col + 1'b1;
      if (text_col >= COLS) queue_scroll();
    end
  endfunction

  // offer one character word, with bursts and gaps on the sender side
  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 40);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (in_stall);
    predict_char(c);
    chars_sent++;
  endtask

  // hold the sender until every predicted word has come out
  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  // full line of field extremes, scroll from the last column
  task automatic test_full_line();
    logic [CHAR_W-1:0] sample [16];
    sample = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h55, 8'haa, 8'h09, 8'h0b,
               8'h0c, 8'h0e, 8'h01, 8'hfe, 8'h20, 8'h41, 8'h7e, 8'h5a};
    for (int i = 0; i < COLS; i++) send_char(sample[i % 16]);
  endtask

  // newline with nothing typed gives a blank bottom row
  task automatic test_newline_empty();
    send_char(CH_NEWLINE);
  endtask

  // carriage return stores nothing and moves no column
  task automatic test_return_ignored();
    send_char(CH_RETURN);
    send_char(8'h41);
    send_char(CH_RETURN);
    send_char(CH_NEWLINE);
  endtask

  // random text lines, mostly well formed, some raw noise
  task automatic test_random_text(input int count);
    int                len;
    bit                drained;
    logic [CHAR_W-1:0] c;
    drained = 1'b0;
    while (chars_sent < count) begin
      // one stretch with no idling on either side
      idle_on  = !(chars_sent > count / 4 && chars_sent < count / 3);
      stall_on = idle_on;
      if (!drained && chars_sent > count / 2) begin
        drain_words();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(0, COLS);
        for (int i = 0; i < len; i++) begin
          c = CHAR_W'($urandom_range(0, 255));
          if (c == CH_NEWLINE) c = 8'h4e;
          if ($urandom_range(0, 7) == 0) send_char(CH_RETURN);
          send_char(c);
        end
        if (len < COLS) send_char(CH_NEWLINE);
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_char(CHAR_W'($urandom_range(0, 255)));
      end
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // receiver stall pattern, with a random style picked whenever stall_phase[6:0] is zero
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_phase <= '0;
      out_stall   <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase[6:0] == 0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      if (!stall_on) begin
        out_stall <= 1'b0;
      end else begin
        case (stall_mode)
          STALL_NONE:   out_stall <= 1'b0;
          STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
          STALL_BURST:  out_stall <= stall_phase[4];
          default:      out_stall <= stall_phase[0];
        endcase
      end
    end
  end

  // compare each accepted display word with the oldest prediction
  always @(posedge clk) begin : word_check
    disp_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: op=%0d value=%02h last=%0d", out_op, out_value, out_last);
        fails++;
      end else begin
        want = pending_words.pop_front();
        words_seen++;
        if (out_op !== want.op) begin
          $error("op: expected %0d, got %0d", want.op, out_op);
          fails++;
        end
        if (out_value !== want.value) begin
          $error("value: expected %02h, got %02h", want.value, out_value);
          fails++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_last);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < COLS; i++) begin
      line_chars[i] = CH_SPACE;
      bottom_row[i] = CH_SPACE;
    end
    text_col = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_line();
    test_newline_empty();
    test_return_ignored();
    drain_words();
    test_random_text(RAND_CHARS);

    // let the last scroll finish and watch for stray words
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (pending_words.size() != 0) fails++;

    $display("%0d characters sent, %0d scrolls, %0d display words checked",
             chars_sent, scrolls, words_seen);
    $display("covered full lines, blank newlines, ignored returns, stalls and gaps");
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/trsts_pkg.sv
rtl/trsts_store.sv
rtl/trsts_seq.sv
rtl/two_row_scrolling_text_sequencer_unit.sv
rtl/trsts_checker.sv
test/two_row_scrolling_text_sequencer_unit_test.sv
